FILE: rtl/core/bzct_pkg.sv
// Shared constants, register codes and result type for the BLDC commutation timer.
package bzct_pkg;

    // Averaging window: number of intervals that form the mean
    localparam int WINDOW_DEPTH = 6;
    localparam int HELD_DEPTH   = WINDOW_DEPTH - 1;

    // Field widths
    localparam int CNT_W      = 16;
    localparam int LEVEL_W    = 12;
    localparam int WIN_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COMP_W     = 2;

    // Interval sum and divide by 2*WINDOW_DEPTH through a reciprocal multiply
    localparam int SUM_W       = CNT_W + $clog2(WINDOW_DEPTH);
    localparam int DIVISOR     = 2 * WINDOW_DEPTH;
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    // Saturation limits
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CROSS = 1'b1;

    // Comparator codes
    localparam logic [COMP_W-1:0] COMP_MODE = 2'd2;
    localparam logic [COMP_W-1:0] COMP_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WIN_OFS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_WIN_OFS  = 3'd5;

    // Configuration reset values
    localparam logic [CNT_W-1:0]          RST_DELAY_OFFSET = 16'd0;
    localparam logic [LEVEL_W-1:0]        RST_HIGH_THR     = 12'd300;
    localparam logic [LEVEL_W-1:0]        RST_LOW_THR      = 12'd250;
    localparam logic [LEVEL_W-1:0]        RST_DAC_BASE     = 12'd1900;
    localparam logic signed [LEVEL_W-1:0] RST_HIGH_WIN_OFS = -12'sd80;
    localparam logic signed [LEVEL_W-1:0] RST_LOW_WIN_OFS  = 12'sd300;

    // One result beat
    typedef struct packed {
        logic               commutate;
        logic               crossing_taken;
        logic [CNT_W-1:0]   compare_value;
        logic               high_side_sensing;
        logic               dac_write;
        logic [LEVEL_W-1:0] dac_value;
        logic               window_write;
        logic [WIN_W-1:0]   window_compare;
    } result_t;

endpackage

FILE: rtl/core/bldc_zero_cross_commutation_timer.sv
// Top level: sensorless BLDC commutation timer with zero-crossing capture.
//
// Input channel (in_valid/in_ready): one beat per timer tick or comparator
// zero crossing, with the drive level and reference request for mode switching.
// Output channel (out_valid/out_ready): exactly one result beat per input beat,
// in order: commutate strobe, crossing taken, compare value, sensing mode and
// the DAC and window-compare writes.
// Config channel (cfg_valid/cfg_ready): register index and data; always ready,
// indexes above 5 are dropped. Write only while the block is idle.
// Each result is registered by the same edge that accepts its input beat.
// Throughput: one beat per cycle while out_ready is high; each item is handled in
// a single pass from the accepting edge to the result register.
// The compare reload uses a running window sum and one constant reciprocal
// multiply in that same pass.
// Stall: while a result waits on out_ready, in_ready follows out_ready, so a
// new beat is taken in the same cycle the held result leaves.
// Reset: counter, window, compare, wait flag, sensing mode and last reference
// clear; config registers load their defaults; no result is pending.
module bldc_zero_cross_commutation_timer
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [bzct_pkg::COMP_W-1:0]       comparator,
    input  logic [bzct_pkg::LEVEL_W-1:0]      drive_level,
    input  logic [bzct_pkg::LEVEL_W-1:0]      reference_request,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              commutate,
    output logic                              crossing_taken,
    output logic [bzct_pkg::CNT_W-1:0]        compare_value,
    output logic                              high_side_sensing,
    output logic                              dac_write,
    output logic [bzct_pkg::LEVEL_W-1:0]      dac_value,
    output logic                              window_write,
    output logic [bzct_pkg::WIN_W-1:0]        window_compare,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bzct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bzct_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers
    logic [bzct_pkg::CNT_W-1:0]          delay_offset_reg;
    logic [bzct_pkg::LEVEL_W-1:0]        high_thr_reg;
    logic [bzct_pkg::LEVEL_W-1:0]        low_thr_reg;
    logic [bzct_pkg::LEVEL_W-1:0]        dac_base_reg;
    logic signed [bzct_pkg::LEVEL_W-1:0] high_win_ofs_reg;
    logic signed [bzct_pkg::LEVEL_W-1:0] low_win_ofs_reg;

    // Timer state
    logic [bzct_pkg::CNT_W-1:0]   counter_reg,  counter_next;
    logic [bzct_pkg::CNT_W-1:0]   window_reg [bzct_pkg::HELD_DEPTH];
    logic [bzct_pkg::SUM_W-1:0]   held_sum_reg, held_sum_next;
    logic [bzct_pkg::CNT_W-1:0]   compare_reg,  compare_next;
    logic                         waiting_reg,  waiting_next;
    logic                         mode_reg,     mode_next;
    logic [bzct_pkg::LEVEL_W-1:0] last_ref_reg, last_ref_next;

    // Result register
    logic                 out_valid_reg;
    bzct_pkg::result_t    result_reg, result_next;

    // Datapath signals
    logic                                in_fire;
    logic                                take_cross;
    logic [bzct_pkg::CNT_W-1:0]          counter_inc;
    logic [bzct_pkg::SUM_W-1:0]          sum_full;
    logic [bzct_pkg::PROD_W-1:0]         product;
    logic [bzct_pkg::CNT_W-1:0]          quotient;
    logic [bzct_pkg::LEVEL_W:0]          level_sum;
    logic [bzct_pkg::LEVEL_W-1:0]        level_sat;
    logic signed [bzct_pkg::LEVEL_W+1:0] high_win_sum;
    logic signed [bzct_pkg::LEVEL_W+1:0] low_win_sum;
    logic [bzct_pkg::WIN_W-1:0]          high_win_clamp;
    logic [bzct_pkg::WIN_W-1:0]          low_win_clamp;
    logic                                above_high;
    logic                                at_or_below_low;
    logic                                mode_mid;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_offset_reg <= bzct_pkg::RST_DELAY_OFFSET;
            high_thr_reg     <= bzct_pkg::RST_HIGH_THR;
            low_thr_reg      <= bzct_pkg::RST_LOW_THR;
            dac_base_reg     <= bzct_pkg::RST_DAC_BASE;
            high_win_ofs_reg <= bzct_pkg::RST_HIGH_WIN_OFS;
            low_win_ofs_reg  <= bzct_pkg::RST_LOW_WIN_OFS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bzct_pkg::CFG_DELAY_OFFSET: delay_offset_reg <= cfg_data;
                bzct_pkg::CFG_HIGH_THR:     high_thr_reg     <= cfg_data[bzct_pkg::LEVEL_W-1:0];
                bzct_pkg::CFG_LOW_THR:      low_thr_reg      <= cfg_data[bzct_pkg::LEVEL_W-1:0];
                bzct_pkg::CFG_DAC_BASE:     dac_base_reg     <= cfg_data[bzct_pkg::LEVEL_W-1:0];
                bzct_pkg::CFG_HIGH_WIN_OFS: high_win_ofs_reg <= cfg_data[bzct_pkg::LEVEL_W-1:0];
                bzct_pkg::CFG_LOW_WIN_OFS:  low_win_ofs_reg  <= cfg_data[bzct_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Interval averaging: running window sum plus reciprocal multiply
    assign counter_inc   = counter_reg + 1'b1;
    assign take_cross    = (operation == bzct_pkg::OP_CROSS) && !waiting_reg &&
                           (comparator != bzct_pkg::COMP_NONE);
    assign sum_full      = held_sum_reg + bzct_pkg::SUM_W'(counter_reg);
    assign held_sum_next = sum_full - bzct_pkg::SUM_W'(window_reg[0]);
    assign product       = bzct_pkg::PROD_W'(sum_full) * bzct_pkg::PROD_W'(bzct_pkg::RECIP);
    assign quotient      = product[bzct_pkg::RECIP_SHIFT +: bzct_pkg::CNT_W];

    // Reference level with saturation, window compare values with clamp at zero
    assign level_sum = {1'b0, dac_base_reg} + {1'b0, reference_request};
    assign level_sat = level_sum[bzct_pkg::LEVEL_W] ? bzct_pkg::LEVEL_MAX
                                                     : level_sum[bzct_pkg::LEVEL_W-1:0];
    assign high_win_sum = $signed({2'b00, drive_level}) +
                          (bzct_pkg::LEVEL_W+2)'(high_win_ofs_reg);
    assign low_win_sum  = $signed({2'b00, drive_level}) +
                          (bzct_pkg::LEVEL_W+2)'(low_win_ofs_reg);
    assign high_win_clamp = high_win_sum[bzct_pkg::LEVEL_W+1] ? '0
                          : high_win_sum[bzct_pkg::WIN_W-1:0];
    assign low_win_clamp  = low_win_sum[bzct_pkg::LEVEL_W+1] ? '0
                          : low_win_sum[bzct_pkg::WIN_W-1:0];

    assign above_high      = drive_level > high_thr_reg;
    assign at_or_below_low = drive_level <= low_thr_reg;

    // Step the timer and build the result beat
    always_comb
    begin
        counter_next  = counter_reg;
        compare_next  = compare_reg;
        waiting_next  = waiting_reg;
        mode_next     = mode_reg;
        mode_mid      = mode_reg;
        last_ref_next = last_ref_reg;
        result_next   = '0;

        if (operation == bzct_pkg::OP_TICK)
        begin
            counter_next = counter_inc;
            if (waiting_reg && (counter_inc == compare_reg))
            begin
                result_next.commutate = 1'b1;
                waiting_next          = 1'b0;
            end
        end
        else if (take_cross)
        begin
            compare_next                = quotient + delay_offset_reg;
            counter_next                = '0;
            waiting_next                = 1'b1;
            result_next.crossing_taken  = 1'b1;

            if (comparator == bzct_pkg::COMP_MODE)
            begin
                // Switch to high side
                if (above_high && !mode_reg)
                begin
                    result_next.dac_write      = 1'b1;
                    result_next.dac_value      = level_sat;
                    result_next.window_write   = 1'b1;
                    result_next.window_compare = high_win_clamp;
                    mode_mid                   = 1'b1;
                end
                // Refresh the reference on a changed request
                if (above_high && mode_mid && (reference_request != last_ref_reg))
                begin
                    result_next.dac_write = 1'b1;
                    result_next.dac_value = level_sat;
                    last_ref_next         = reference_request;
                end
                mode_next = mode_mid;
                // Drop back to low side
                if (at_or_below_low && mode_mid)
                begin
                    result_next.dac_write      = 1'b1;
                    result_next.dac_value      = '0;
                    result_next.window_write   = 1'b1;
                    result_next.window_compare = low_win_clamp;
                    mode_next                  = 1'b0;
                end
            end
        end

        result_next.compare_value     = compare_next;
        result_next.high_side_sensing = mode_next;
    end

    // Timer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= '0;
            held_sum_reg <= '0;
            compare_reg  <= '0;
            waiting_reg  <= 1'b0;
            mode_reg     <= 1'b0;
            last_ref_reg <= '0;
            for (int i = 0; i < bzct_pkg::HELD_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (in_fire)
        begin
            counter_reg  <= counter_next;
            compare_reg  <= compare_next;
            waiting_reg  <= waiting_next;
            mode_reg     <= mode_next;
            last_ref_reg <= last_ref_next;
            // Shift the window on a taken crossing
            if (take_cross)
            begin
                held_sum_reg <= held_sum_next;
                for (int i = 0; i < bzct_pkg::HELD_DEPTH - 1; i++)
                begin
                    window_reg[i] <= window_reg[i+1];
                end
                window_reg[bzct_pkg::HELD_DEPTH-1] <= counter_reg;
            end
        end
    end

    // Result register: load on accept, release on output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign commutate         = result_reg.commutate;
    assign crossing_taken    = result_reg.crossing_taken;
    assign compare_value     = result_reg.compare_value;
    assign high_side_sensing = result_reg.high_side_sensing;
    assign dac_write         = result_reg.dac_write;
    assign dac_value         = result_reg.dac_value;
    assign window_write      = result_reg.window_write;
    assign window_compare    = result_reg.window_compare;

    // A taken crossing arms the wait flag and restarts the interval count
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && take_cross) |=> (waiting_reg && (counter_reg == '0)))
        else $error("crossing did not arm the commutation wait");

    // A commutation and a crossing never share one result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(commutate && crossing_taken))
        else $error("commutate and crossing_taken both set");

    // Sensing writes only come with a taken crossing
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (dac_write || window_write)) |-> crossing_taken)
        else $error("sensing write without a taken crossing");

    // A low-side result never issues a nonzero reference level
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dac_write && !high_side_sensing) |-> (dac_value == '0))
        else $error("nonzero reference issued in low-side mode");

endmodule
